// File: hw/rtl/asc_pkg.sv
package asc_pkg;

   localparam int unsigned CAP_W = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = '1;

   typedef struct packed {
      logic [7:0] ch;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] out_char;
      logic [2:0] status;
   } rsp_type;

   // scanner modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_BLOCK  = 2'd1;
   localparam logic [1:0] MODE_LINE   = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;

   // result status codes
   localparam logic [2:0] ST_IN_LINE     = 3'd0;
   localparam logic [2:0] ST_LINE_DONE   = 3'd1;
   localparam logic [2:0] ST_BAD_COMMENT = 3'd2;
   localparam logic [2:0] ST_BAD_STRING  = 3'd3;
   localparam logic [2:0] ST_NO_SPACE    = 3'd4;
   localparam logic [2:0] ST_NO_TERM     = 3'd5;
   localparam logic [2:0] ST_NONE        = 3'd0;

   // character codes
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

// File: hw/rtl/asm_source_comment_stripper_core.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  asc_pkg::req_type {ch, chunk_end}
// rsp      out        rsp_valid/rsp_stall  asc_pkg::rsp_type {emit, out_char, status}
// csr      in         csr_valid/csr_ready  out_capacity, 16 bits
//
// One character per clock sustained while rsp_stall is low; each item passes the input
// register, then a single filter pass, then the result register.
// Reset is synchronous: mode normal, no sticky error, count zero, capacity full.
// A stalled result holds; the input register then holds too and req_stall rises,
// so at most one item waits behind a stalled result.
module asm_source_comment_stripper_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  asc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output asc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [asc_pkg::CAP_W-1:0] csr_data
);

   // input register
   logic             req_valid_ff;
   asc_pkg::req_type req_data_ff;

   // result register
   logic             rsp_valid_ff;
   asc_pkg::rsp_type rsp_data_ff;

   // capacity register
   logic [asc_pkg::CAP_W-1:0] capacity_ff;

   logic             rsp_free;
   logic             advance;
   asc_pkg::rsp_type result;

   // result slot can take a new item when empty or when its transfer completes
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // an item moves from input register through the filter into the result register
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;

   // the user must issue config writes only while idle; the block does not enforce this, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= asc_pkg::CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_data_ff <= req_data;
      end
   end

   asc_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (req_data_ff),
      .capacity (capacity_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/asc_filter.sv
module asc_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  asc_pkg::req_type           item,
   input  logic [asc_pkg::CAP_W-1:0]  capacity,
   output asc_pkg::rsp_type           result
);

   logic [1:0]                mode_ff, mode_in;
   logic                      space_ff, space_in;
   logic [asc_pkg::CAP_W-1:0] count_ff, count_in;
   logic [2:0]                sticky_ff, sticky_in;

   logic       line_end;
   logic       emit;
   logic [7:0] out_ch;
   logic [7:0] plain_ch;
   logic       done;
   logic       abort;
   logic [2:0] err_code;
   logic [2:0] status;

   assign line_end = (item.ch == asc_pkg::CH_LF) || (item.ch == asc_pkg::CH_NUL);
   assign plain_ch = (item.ch == asc_pkg::CH_TAB) ? asc_pkg::CH_SPACE : item.ch;

   always_comb begin
      mode_in   = mode_ff;
      space_in  = space_ff;
      count_in  = count_ff;
      sticky_in = sticky_ff;
      emit      = 1'b0;
      out_ch    = asc_pkg::CH_NUL;
      done      = 1'b0;
      abort     = 1'b0;
      err_code  = asc_pkg::ST_NONE;
      status    = asc_pkg::ST_IN_LINE;

      if (sticky_ff != asc_pkg::ST_NONE) begin
         status = sticky_ff;
      end else if (count_ff >= capacity) begin
         sticky_in = asc_pkg::ST_NO_SPACE;
         status    = asc_pkg::ST_NO_SPACE;
      end else begin
         case (mode_ff)
            asc_pkg::MODE_NORMAL: begin
               if (item.ch == asc_pkg::CH_LBRACE) begin
                  mode_in = asc_pkg::MODE_BLOCK;
               end else if (item.ch == asc_pkg::CH_SEMI) begin
                  mode_in = asc_pkg::MODE_LINE;
               end else if (item.ch == asc_pkg::CH_RBRACE) begin
                  abort    = 1'b1;
                  err_code = asc_pkg::ST_BAD_COMMENT;
               end else if (item.ch == asc_pkg::CH_QUOTE) begin
                  emit    = 1'b1;
                  out_ch  = item.ch;
                  mode_in = asc_pkg::MODE_STRING;
               end else if (item.ch == asc_pkg::CH_CR) begin
                  emit = 1'b0;
               end else if (line_end) begin
                  emit   = 1'b1;
                  out_ch = item.ch;
                  done   = 1'b1;
               end else if (!((plain_ch == asc_pkg::CH_SPACE) && space_ff)) begin
                  emit     = 1'b1;
                  out_ch   = plain_ch;
                  space_in = (plain_ch == asc_pkg::CH_SPACE);
               end
            end
            asc_pkg::MODE_BLOCK: begin
               if (item.ch == asc_pkg::CH_RBRACE) begin
                  mode_in = asc_pkg::MODE_NORMAL;
               end else if (line_end) begin
                  emit   = 1'b1;
                  out_ch = item.ch;
                  done   = 1'b1;
               end
            end
            asc_pkg::MODE_LINE: begin
               if (line_end) begin
                  emit    = 1'b1;
                  out_ch  = item.ch;
                  done    = 1'b1;
                  mode_in = asc_pkg::MODE_NORMAL;
               end
            end
            default: begin
               if (line_end) begin
                  abort    = 1'b1;
                  err_code = asc_pkg::ST_BAD_STRING;
               end else begin
                  emit   = 1'b1;
                  out_ch = item.ch;
                  if (item.ch == asc_pkg::CH_QUOTE) begin
                     mode_in = asc_pkg::MODE_NORMAL;
                  end
               end
            end
         endcase

         if (abort) begin
            mode_in   = mode_ff;
            space_in  = space_ff;
            sticky_in = err_code;
            status    = err_code;
         end else begin
            count_in = count_ff + asc_pkg::CAP_W'(emit);
            if (done) begin
               space_in = 1'b0;
               status   = asc_pkg::ST_LINE_DONE;
            end else if (count_in >= capacity) begin
               sticky_in = asc_pkg::ST_NO_SPACE;
               status    = asc_pkg::ST_NO_SPACE;
            end else if (item.chunk_end) begin
               space_in = 1'b0;
               status   = asc_pkg::ST_NO_TERM;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= asc_pkg::MODE_NORMAL;
         space_ff  <= 1'b0;
         count_ff  <= '0;
         sticky_ff <= asc_pkg::ST_NONE;
      end else if (advance) begin
         mode_ff   <= mode_in;
         space_ff  <= space_in;
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

   assign result.emit     = emit;
   assign result.out_char = emit ? out_ch : asc_pkg::CH_NUL;
   assign result.status   = status;

endmodule

// File: hw/rtl/asc_checker.sv
module asc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input asc_pkg::rsp_type rsp_data
);

   // held result stays put until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // no character without emit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.emit |-> rsp_data.out_char == asc_pkg::CH_NUL)
      else $error("out_char set without emit");

   // line done always carries the terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == asc_pkg::ST_LINE_DONE |->
         rsp_data.emit &&
         (rsp_data.out_char == asc_pkg::CH_LF || rsp_data.out_char == asc_pkg::CH_NUL))
      else $error("line done without terminator");

   // syntax errors are sticky across back-to-back transfers
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid && !rsp_stall &&
         (rsp_data.status == asc_pkg::ST_BAD_COMMENT ||
          rsp_data.status == asc_pkg::ST_BAD_STRING)) && rsp_valid |->
         rsp_data.status == $past(rsp_data.status) && !rsp_data.emit)
      else $error("sticky error lost");

endmodule

bind asm_source_comment_stripper_core asc_checker u_asc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
